/* hw/rtl/slnt_pkg.sv */
// Shared types and constants for the sorted leaf node table.
`default_nettype none

package slnt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 7;
  localparam int EIDX_W   = 8;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOCATE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_DUP      = 3'd2,
    STATUS_NOTFOUND = 3'd3,
    STATUS_RANGE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] page;
    logic signed [KEY_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    func_t                   func;
    logic signed [KEY_W-1:0] key_in;
    logic signed [KEY_W-1:0] record_page_in;
    logic signed [KEY_W-1:0] record_slot_in;
    logic [EIDX_W-1:0]       entry_index;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        position;
    logic signed [KEY_W-1:0] key_out;
    logic signed [KEY_W-1:0] record_page_out;
    logic signed [KEY_W-1:0] record_slot_out;
    logic [POS_W-1:0]        entry_count;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/sorted_leaf_node_table.sv */
// Top level of the sorted leaf node table: one B+tree leaf node with insert, locate and read.
`default_nettype none

// This block holds one B+tree leaf node of up to CAPACITY entries (a signed
// 32-bit key with a page and slot record id), kept in ascending key order in
// a memory with one write port and one registered read port, plus an explicit
// entry count. Every request item yields exactly one response item that
// reports the entry count after the operation. One item is worked on at a
// time; the request side stalls from acceptance until the response is handed
// to the output register, which may still be waiting on the consumer while
// the next request is taken. A locate scans entries from the front until it
// finds the key, passes it or runs past the count; an insert scans the same
// way and, for a new key, then moves every later entry up before it writes
// the new entry into the gap. A full-node insert, an out-of-range read or the
// unused operation code go to the response without touching the memory. A
// finished item waits in its last state for as long as the output register
// still holds an item the consumer has not taken. The slowest items are an
// insert at the front of a node with one free entry, or a locate that runs
// past the end of a full node. Each compared or moved entry needs a read to
// be issued and then the registered data to be used, and the single key
// comparator serves the whole scan. No clearing pass is needed after reset;
// the contents of entries at or above the count are never used.
module sorted_leaf_node_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire slnt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output slnt_pkg::rsp_t      rsp
);

  // Entry storage: one memory, one write port and one registered read port.
  slnt_pkg::entry_t mem [slnt_pkg::CAPACITY];
  slnt_pkg::entry_t rd_entry;
  logic                         mem_we;
  logic [slnt_pkg::IDX_W-1:0]   mem_waddr;
  logic [slnt_pkg::IDX_W-1:0]   mem_raddr;
  slnt_pkg::entry_t             mem_wdata;

  // Sequencer state and working registers.
  slnt_pkg::state_t             state, state_next;
  slnt_pkg::req_t               req_q;
  logic [slnt_pkg::CNT_W-1:0]   count, count_next;
  logic [slnt_pkg::CNT_W-1:0]   scan_idx, scan_idx_next;
  logic [slnt_pkg::CNT_W-1:0]   shift_idx, shift_idx_next;
  logic [slnt_pkg::CNT_W-1:0]   shift_dec;
  slnt_pkg::status_t            res_status, res_status_next;
  logic [slnt_pkg::POS_W-1:0]   res_pos, res_pos_next;
  slnt_pkg::entry_t             res_entry, res_entry_next;

  logic key_eq;
  logic key_lt;
  logic idx_out_of_range;
  logic node_full;
  logic rsp_free;
  logic rsp_load;
  slnt_pkg::entry_t new_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[mem_raddr];
  end

  // The one shared comparator: the search key against the entry just read.
  assign key_eq = (rd_entry.key == req_q.key_in);
  assign key_lt = ($signed(req_q.key_in) < $signed(rd_entry.key));

  assign idx_out_of_range = (32'(req_q.entry_index) >= 32'(count));
  assign node_full        = (count == slnt_pkg::CNT_W'(slnt_pkg::CAPACITY));
  assign shift_dec        = shift_idx - slnt_pkg::CNT_W'(1);
  assign new_entry        = {req_q.key_in, req_q.record_page_in, req_q.record_slot_in};

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = (state == slnt_pkg::S_DONE) && rsp_free;
  assign req_stall = (state != slnt_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slnt_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == slnt_pkg::S_IDLE) && req_valid) begin
      req_q <= req;
    end
    scan_idx   <= scan_idx_next;
    shift_idx  <= shift_idx_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_entry  <= res_entry_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_idx_next   = scan_idx;
    shift_idx_next  = shift_idx;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_entry_next  = res_entry;
    mem_we          = 1'b0;
    mem_waddr       = scan_idx[slnt_pkg::IDX_W-1:0];
    mem_wdata       = new_entry;
    mem_raddr       = scan_idx[slnt_pkg::IDX_W-1:0];

    case (state)
      slnt_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = slnt_pkg::S_START;
        end
      end

      slnt_pkg::S_START: begin
        res_status_next = slnt_pkg::STATUS_OK;
        res_pos_next    = '0;
        res_entry_next  = '0;
        scan_idx_next   = '0;
        case (req_q.func)
          slnt_pkg::FUNC_INSERT: begin
            if (node_full) begin
              res_status_next = slnt_pkg::STATUS_FULL;
              state_next      = slnt_pkg::S_DONE;
            end else begin
              state_next = slnt_pkg::S_SCAN_RD;
            end
          end
          slnt_pkg::FUNC_LOCATE: begin
            state_next = slnt_pkg::S_SCAN_RD;
          end
          slnt_pkg::FUNC_READ: begin
            if (idx_out_of_range) begin
              res_status_next = slnt_pkg::STATUS_RANGE;
              state_next      = slnt_pkg::S_DONE;
            end else begin
              mem_raddr  = req_q.entry_index[slnt_pkg::IDX_W-1:0];
              state_next = slnt_pkg::S_READ_WAIT;
            end
          end
          default: begin
            state_next = slnt_pkg::S_DONE;
          end
        endcase
      end

      slnt_pkg::S_SCAN_RD: begin
        if (scan_idx == count) begin
          // Ran off the end: the insertion point is the count.
          res_pos_next = slnt_pkg::POS_W'(scan_idx);
          if (req_q.func == slnt_pkg::FUNC_INSERT) begin
            shift_idx_next = count;
            state_next     = slnt_pkg::S_SHIFT_RD;
          end else begin
            res_status_next = slnt_pkg::STATUS_NOTFOUND;
            state_next      = slnt_pkg::S_DONE;
          end
        end else begin
          state_next = slnt_pkg::S_SCAN_CMP;
        end
      end

      slnt_pkg::S_SCAN_CMP: begin
        if (key_eq) begin
          res_pos_next = slnt_pkg::POS_W'(scan_idx);
          if (req_q.func == slnt_pkg::FUNC_INSERT) begin
            res_status_next = slnt_pkg::STATUS_DUP;
          end
          state_next = slnt_pkg::S_DONE;
        end else if (key_lt) begin
          res_pos_next = slnt_pkg::POS_W'(scan_idx);
          if (req_q.func == slnt_pkg::FUNC_INSERT) begin
            shift_idx_next = count;
            state_next     = slnt_pkg::S_SHIFT_RD;
          end else begin
            res_status_next = slnt_pkg::STATUS_NOTFOUND;
            state_next      = slnt_pkg::S_DONE;
          end
        end else begin
          scan_idx_next = scan_idx + slnt_pkg::CNT_W'(1);
          state_next    = slnt_pkg::S_SCAN_RD;
        end
      end

      slnt_pkg::S_SHIFT_RD: begin
        if (shift_idx == scan_idx) begin
          // Every later entry has moved up; drop the new one into the gap.
          mem_we     = 1'b1;
          mem_waddr  = scan_idx[slnt_pkg::IDX_W-1:0];
          mem_wdata  = new_entry;
          count_next = count + slnt_pkg::CNT_W'(1);
          state_next = slnt_pkg::S_DONE;
        end else begin
          mem_raddr  = shift_dec[slnt_pkg::IDX_W-1:0];
          state_next = slnt_pkg::S_SHIFT_WR;
        end
      end

      slnt_pkg::S_SHIFT_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = shift_idx[slnt_pkg::IDX_W-1:0];
        mem_wdata      = rd_entry;
        shift_idx_next = shift_dec;
        state_next     = slnt_pkg::S_SHIFT_RD;
      end

      slnt_pkg::S_READ_WAIT: begin
        res_entry_next = rd_entry;
        state_next     = slnt_pkg::S_DONE;
      end

      slnt_pkg::S_DONE: begin
        if (rsp_free) begin
          state_next = slnt_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slnt_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status          <= res_status;
      rsp.position        <= res_pos;
      rsp.key_out         <= res_entry.key;
      rsp.record_page_out <= res_entry.page;
      rsp.record_slot_out <= res_entry.slot;
      rsp.entry_count     <= slnt_pkg::POS_W'(count);
    end
  end

  // The node never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (rst)
    count <= slnt_pkg::CNT_W'(slnt_pkg::CAPACITY))
    else $error("entry count above capacity");

  // The count only ever grows by one, and only when an insert completes.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (count != $past(count))) |->
      ((count == $past(count) + slnt_pkg::CNT_W'(1)) &&
       ($past(state) == slnt_pkg::S_SHIFT_RD)))
    else $error("entry count changed outside an insert");

  // The memory is written only while an insert is moving or placing entries.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == slnt_pkg::S_SHIFT_RD) || (state == slnt_pkg::S_SHIFT_WR)))
    else $error("memory written outside the shift phase");

  // A response appears only when the sequencer has finished an item.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(rsp_valid)) |-> ($past(state) == slnt_pkg::S_DONE))
    else $error("response raised without a finished item");

endmodule

`default_nettype wire
